/* src/latency_log2_histogram_stats_macros.svh */
// ---------------------------------------------------------------------------
// latency log2 histogram stats: assertion macros
// Shared concurrent assertion wrappers, clocked on clk_i, off during reset.
// ---------------------------------------------------------------------------
`ifndef LATENCY_LOG2_HISTOGRAM_STATS_MACROS_SVH
`define LATENCY_LOG2_HISTOGRAM_STATS_MACROS_SVH

// condition that must hold at every edge
`define LHS_ASSERT(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// antecedent at one edge implies consequent at the next edge
`define LHS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/lhs_pkg.sv */
// ---------------------------------------------------------------------------
// lhs_pkg
// Types, constants and helpers of the log2 latency histogram block.
// ---------------------------------------------------------------------------
package lhs_pkg;

  localparam int NUM_BINS = 32;
  localparam int BIN_W    = $clog2(NUM_BINS);
  localparam int LAT_W    = 32;
  localparam int SUM_W    = 64;
  // running total of all bins, scaled by 100
  localparam int CUM_W    = LAT_W + BIN_W + 7;
  localparam int DIV_CNT_W = $clog2(SUM_W);

  localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(NUM_BINS - 1);

  typedef struct packed {
    logic             kind;
    logic [LAT_W-1:0] latency;
  } in_item_t;

  typedef struct packed {
    logic [LAT_W-1:0] sample_count;
    logic [LAT_W-1:0] latency_min;
    logic [LAT_W-1:0] latency_max;
    logic [LAT_W-1:0] latency_mean;
    logic [LAT_W-1:0] latency_p99;
    logic             overflow;
  } out_item_t;

  localparam logic KIND_RECORD = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  // bit length of the latency, capped at the last bin
  function automatic logic [BIN_W-1:0] bin_of(input logic [LAT_W-1:0] v);
    logic [5:0] len;
    len = '0;
    for (int i = 0; i < LAT_W; i++) begin
      if (v[i]) len = 6'(i + 1);
    end
    if (len > 6'(NUM_BINS - 1)) len = 6'(NUM_BINS - 1);
    return BIN_W'(len);
  endfunction

endpackage

/* src/lhs_div.sv */
// ---------------------------------------------------------------------------
// lhs_div
// Restoring divider, one quotient bit per cycle, 64-bit by 32-bit.
// ---------------------------------------------------------------------------
module lhs_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [lhs_pkg::SUM_W-1:0]    dividend_i,
  input  logic [lhs_pkg::LAT_W-1:0]    divisor_i,
  output logic                         busy_o,
  output logic [lhs_pkg::SUM_W-1:0]    quotient_o
);
  import lhs_pkg::*;

  logic                 busy_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [SUM_W-1:0]     dvd_q;
  logic [LAT_W-1:0]     rem_q;
  logic [LAT_W-1:0]     dsr_q;

  logic [LAT_W:0]       trial;
  logic                 fits;
  logic [LAT_W:0]       diff;

  assign trial = {rem_q, dvd_q[SUM_W-1]};
  assign fits  = trial >= {1'b0, dsr_q};
  assign diff  = trial - {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      dvd_q  <= '0;
      rem_q  <= '0;
      dsr_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
      dvd_q  <= dividend_i;
      rem_q  <= '0;
      dsr_q  <= divisor_i;
    end else if (busy_q) begin
      // shift in one dividend bit, keep the quotient bit in its place
      rem_q <= fits ? diff[LAT_W-1:0] : trial[LAT_W-1:0];
      dvd_q <= {dvd_q[SUM_W-2:0], fits};
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == DIV_CNT_W'(SUM_W - 1)) busy_q <= 1'b0;
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = dvd_q;

endmodule

/* src/latency_log2_histogram_stats.sv */
// ---------------------------------------------------------------------------
// latency_log2_histogram_stats
// Log2 latency histogram with min, max, mean and p99 reporting.
// ---------------------------------------------------------------------------
// A record transfer files the latency into the bin given by its bit length and
// updates min, max, sum and count; it reads the bin from the single-port bin
// memory in ST_IDLE and writes it back in ST_REC. A report transfer walks the
// bins, each through ST_RD, ST_ACC and ST_CMP, until the running total reaches
// count*99/100 or the last bin, while a serial divider forms the mean; with no
// samples a report skips both and gives all zeros. A finished report sits in
// the output register, so records go on while it waits.
// Bin memory contents are cleared at reset through per-bin valid bits.
// ---------------------------------------------------------------------------
module latency_log2_histogram_stats (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  lhs_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output lhs_pkg::out_item_t  out_data_o
);
  import lhs_pkg::*;
  `include "latency_log2_histogram_stats_macros.svh"

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REC,
    ST_RD,
    ST_ACC,
    ST_CMP,
    ST_WAIT,
    ST_OUT
  } state_e;

  state_e            state_q;

  logic [LAT_W-1:0]  min_q, max_q, count_q;
  logic [SUM_W-1:0]  sum_q;
  logic              sat_q;

  // bin memory
  logic [LAT_W-1:0]  bin_mem [NUM_BINS];
  logic [NUM_BINS-1:0] bin_vld_q;
  logic [LAT_W-1:0]  rdata_q;
  logic              rvld_q;
  logic              mem_re, mem_we;
  logic [BIN_W-1:0]  mem_raddr;
  logic [LAT_W-1:0]  mem_wdata;

  logic [BIN_W-1:0]  rec_bin_q;
  logic [BIN_W-1:0]  walk_idx_q;
  logic [BIN_W-1:0]  hit_q;
  logic [CUM_W-1:0]  cum_q, target_q;

  out_item_t         res_q, out_q;
  logic              out_valid_q;

  logic              in_xfer, rec_xfer, rpt_xfer, out_free;
  logic [BIN_W-1:0]  in_bin;
  logic [LAT_W-1:0]  bin_cur;
  logic [CUM_W-1:0]  bin_x100;
  logic [SUM_W:0]    sum_add;
  logic              div_start, div_busy;
  logic [SUM_W-1:0]  quotient;

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign rec_xfer = in_xfer && (in_data_i.kind == KIND_RECORD);
  assign rpt_xfer = in_xfer && (in_data_i.kind == KIND_REPORT);
  assign out_free = !out_valid_q || !out_stall_i;
  assign in_bin   = bin_of(in_data_i.latency);
  assign bin_cur  = rvld_q ? rdata_q : '0;
  assign bin_x100 = (CUM_W'(bin_cur) << 6) + (CUM_W'(bin_cur) << 5) + (CUM_W'(bin_cur) << 2);
  assign sum_add  = {1'b0, sum_q} + (SUM_W + 1)'(in_data_i.latency);

  assign div_start = rpt_xfer && (count_q != '0);

  assign mem_re    = rec_xfer || (state_q == ST_RD);
  assign mem_raddr = (state_q == ST_RD) ? walk_idx_q : in_bin;
  assign mem_we    = (state_q == ST_REC);
  assign mem_wdata = (bin_cur == '1) ? bin_cur : bin_cur + 1'b1;

  always_ff @(posedge clk_i) begin
    if (mem_we) bin_mem[rec_bin_q] <= mem_wdata;
    if (mem_re) rdata_q <= bin_mem[mem_raddr];
  end

  lhs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_q),
    .divisor_i  (count_q),
    .busy_o     (div_busy),
    .quotient_o (quotient)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      min_q       <= '1;
      max_q       <= '0;
      sum_q       <= '0;
      count_q     <= '0;
      sat_q       <= 1'b0;
      bin_vld_q   <= '0;
      rvld_q      <= 1'b0;
      rec_bin_q   <= '0;
      walk_idx_q  <= '0;
      hit_q       <= '0;
      cum_q       <= '0;
      target_q    <= '0;
      res_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (mem_re) rvld_q <= bin_vld_q[mem_raddr];
      if (out_valid_q && !out_stall_i && (state_q != ST_OUT)) out_valid_q <= 1'b0;

      case (state_q)
        ST_IDLE: begin
          if (rec_xfer) begin
            rec_bin_q <= in_bin;
            if (in_data_i.latency < min_q) min_q <= in_data_i.latency;
            if (in_data_i.latency > max_q) max_q <= in_data_i.latency;
            if (sum_add[SUM_W]) begin
              sum_q <= '1;
              sat_q <= 1'b1;
            end else begin
              sum_q <= sum_add[SUM_W-1:0];
            end
            if (count_q == '1) sat_q <= 1'b1;
            else count_q <= count_q + 1'b1;
            state_q <= ST_REC;
          end else if (rpt_xfer) begin
            if (count_q == '0) begin
              res_q   <= '0;
              state_q <= ST_OUT;
            end else begin
              // compare 100*cum + 99 >= 99*count, same as cum >= count*99/100
              target_q   <= (CUM_W'(count_q) << 7) - (CUM_W'(count_q) << 5) + CUM_W'(count_q)
                            + (CUM_W'(count_q) << 1);
              cum_q      <= '0;
              walk_idx_q <= '0;
              state_q    <= ST_RD;
            end
          end
        end
        ST_REC: begin
          bin_vld_q[rec_bin_q] <= 1'b1;
          if (bin_cur == '1) sat_q <= 1'b1;
          state_q <= ST_IDLE;
        end
        ST_RD: begin
          state_q <= ST_ACC;
        end
        ST_ACC: begin
          cum_q   <= cum_q + bin_x100;
          state_q <= ST_CMP;
        end
        ST_CMP: begin
          if ((cum_q + CUM_W'(99) >= target_q) || (walk_idx_q == LAST_BIN)) begin
            hit_q   <= walk_idx_q;
            state_q <= ST_WAIT;
          end else begin
            walk_idx_q <= walk_idx_q + 1'b1;
            state_q    <= ST_RD;
          end
        end
        ST_WAIT: begin
          if (!div_busy) begin
            res_q.sample_count <= count_q;
            res_q.latency_min  <= min_q;
            res_q.latency_max  <= max_q;
            res_q.latency_mean <= (quotient[SUM_W-1:LAT_W] != '0) ? '1
                                                                 : quotient[LAT_W-1:0];
            res_q.latency_p99  <= (32'(hit_q) >= 32'(LAT_W)) ? '1
                                                              : (LAT_W'(1) << hit_q);
            res_q.overflow     <= sat_q;
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            out_q       <= res_q;
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end else if (out_valid_q && !out_stall_i) begin
            out_valid_q <= 1'b0;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `LHS_ASSERT(a_div_start_idle, !(div_start && div_busy), "divider restarted while busy")
  `LHS_ASSERT_NEXT(a_rec_write, rec_xfer, mem_we, "bin write missing after record transfer")
  `LHS_ASSERT_NEXT(a_out_hold, out_valid_q && out_stall_i, out_valid_q && $stable(out_q),
                   "stalled output transfer changed")
  `LHS_ASSERT(a_empty_state, (count_q != '0) || ((sum_q == '0) && (max_q == '0)),
              "sum or max nonzero with no samples")
  `LHS_ASSERT_NEXT(a_wait_needs_div, (state_q == ST_WAIT) && div_busy, state_q == ST_WAIT,
                   "report left wait state before divide finished")

endmodule

/* test/latency_log2_histogram_stats_tb.sv */
// ---------------------------------------------------------------------------
// latency_log2_histogram_stats_tb
// Drives latency records and report requests through the valid/stall input
// channel, predicts every report (count, min, max, mean, p99 bound, overflow)
// in a scoreboard and compares each report transfer field by field. Random
// bursts of records run under four sender/receiver idle patterns, with one long
// output hold-off followed by a full drain in between.
// ---------------------------------------------------------------------------
module latency_log2_histogram_stats_tb;
  import lhs_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned HOLD_CYCLES  = 600;
  localparam int unsigned TAIL_CYCLES  = 300;
  localparam int unsigned PHASE_ITEMS  = 430;

  localparam int unsigned PROFILE_LOG  = 0;
  localparam int unsigned PROFILE_TAIL = 1;
  localparam int unsigned PROFILE_WIDE = 2;

  // running histogram statistics and the reports they predict
  class lhs_scoreboard;
    bit [31:0]   bin_cnt [NUM_BINS];
    bit [31:0]   lat_lo;
    bit [31:0]   lat_hi;
    bit [31:0]   n_samples;
    bit [63:0]   lat_total;
    bit          sat;
    out_item_t   stats_q[$];
    int unsigned n_records;
    int unsigned n_reports;
    int unsigned n_checked;
    int unsigned n_errors;
    bit [31:0]   p99_seen;

    function new();
      foreach (bin_cnt[i]) bin_cnt[i] = '0;
      lat_lo    = '1;
      lat_hi    = '0;
      n_samples = '0;
      lat_total = '0;
      sat       = 1'b0;
      n_records = 0;
      n_reports = 0;
      n_checked = 0;
      n_errors  = 0;
      p99_seen  = '0;
    endfunction

    function void note_input(in_item_t it);
      int unsigned b;
      int unsigned hit;
      bit          found;
      bit [63:0]   quot;
      bit [63:0]   target;
      bit [63:0]   cum;
      out_item_t   want;
      if (it.kind == KIND_RECORD) begin
        n_records++;
        b = 0;
        for (int i = 0; i < LAT_W; i++) begin
          if (it.latency[i]) b = i + 1;
        end
        if (b > NUM_BINS - 1) b = NUM_BINS - 1;
        if (bin_cnt[b] == '1) sat = 1'b1;
        else bin_cnt[b]++;
        if (it.latency < lat_lo) lat_lo = it.latency;
        if (it.latency > lat_hi) lat_hi = it.latency;
        if (lat_total > (64'hFFFF_FFFF_FFFF_FFFF - 64'(it.latency))) begin
          lat_total = '1;
          sat       = 1'b1;
        end else begin
          lat_total += 64'(it.latency);
        end
        if (n_samples == '1) sat = 1'b1;
        else n_samples++;
      end else begin
        n_reports++;
        want = '0;
        if (n_samples != 0) begin
          quot = lat_total / 64'(n_samples);
          target = (64'(n_samples) * 99) / 100;
          hit = NUM_BINS - 1;
          found = 1'b0;
          cum = '0;
          for (int i = 0; i < NUM_BINS; i++) begin
            if (!found) begin
              cum += 64'(bin_cnt[i]);
              if (cum >= target) begin
                hit   = i;
                found = 1'b1;
              end
            end
          end
          want.sample_count = n_samples;
          want.latency_min  = lat_lo;
          want.latency_max  = lat_hi;
          want.latency_mean = (quot > 64'hFFFF_FFFF) ? '1 : quot[31:0];
          want.latency_p99  = (hit >= 32) ? '1 : (32'd1 << hit);
          want.overflow     = sat;
        end
        stats_q = {stats_q, want};
      end
    endfunction

    function void cmp(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        n_errors++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (stats_q.size() == 0) begin
        $error("report transfer with none pending: sample_count %0h", got.sample_count);
        n_errors++;
        return;
      end
      want = stats_q.pop_front();
      n_checked++;
      p99_seen |= got.latency_p99;
      cmp("sample_count", want.sample_count, got.sample_count);
      cmp("latency_min", want.latency_min, got.latency_min);
      cmp("latency_max", want.latency_max, got.latency_max);
      cmp("latency_mean", want.latency_mean, got.latency_mean);
      cmp("latency_p99", want.latency_p99, got.latency_p99);
      cmp("overflow", 32'(want.overflow), 32'(got.overflow));
    endfunction
  endclass

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  in_item_t    in_data_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_item_t   out_data_o;

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  bit          hold_req      = 1'b0;
  int unsigned cycle_cnt     = 0;

  lhs_scoreboard sb = new();

  latency_log2_histogram_stats u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_data_o);
  end

  // receiver: random stalls, or a long hold-off when requested
  initial begin : receiver
    int unsigned held;
    held = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req && held == 0) begin
        hold_req = 1'b0;
        held     = HOLD_CYCLES;
      end
      if (held != 0) begin
        held--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // one input transfer, with random idle cycles ahead of it
  task automatic transfer_item(input logic kind, input logic [LAT_W-1:0] lat);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{kind: kind, latency: lat};
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_input(in_data_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.stats_q.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  function automatic logic [LAT_W-1:0] pick_latency(input int unsigned profile);
    int unsigned      sel;
    int unsigned      len;
    logic [LAT_W-1:0] v;
    sel = $urandom_range(99);
    // mostly tight latencies with a rare far outlier moves the p99 bin around
    if (profile == PROFILE_TAIL) begin
      if (sel < 96) return $urandom_range(400, 50);
      return $urandom;
    end
    if (profile == PROFILE_WIDE && sel < 60) return $urandom;
    if (sel < 6) begin
      case ($urandom_range(3))
        0:       return '0;
        1:       return 32'd1;
        2:       return '1;
        default: return 32'h8000_0000;
      endcase
    end
    // uniform over bit length, so every bin gets samples
    len = $urandom_range(LAT_W);
    if (len == 0) return '0;
    v = 32'($urandom) >> (LAT_W - len);
    v[len-1] = 1'b1;
    return v;
  endfunction

  // bursts of records closed by a report, plus stray reports
  task automatic send_bursts(input int unsigned n_items);
    int unsigned sent;
    int unsigned burst;
    int unsigned profile;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 8) begin
        transfer_item(KIND_REPORT, $urandom);
        sent++;
      end else begin
        burst   = $urandom_range(30, 1);
        profile = $urandom_range(PROFILE_WIDE);
        repeat (burst) begin
          transfer_item(KIND_RECORD, pick_latency(profile));
          sent++;
        end
        transfer_item(KIND_REPORT, $urandom);
        sent++;
      end
    end
  endtask

  initial begin : stimulus
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty histogram, then single samples at the extremes
    transfer_item(KIND_REPORT, '1);
    transfer_item(KIND_RECORD, '0);
    transfer_item(KIND_REPORT, '0);
    transfer_item(KIND_RECORD, '1);
    transfer_item(KIND_REPORT, 32'h5555_5555);
    transfer_item(KIND_RECORD, 32'd1);
    transfer_item(KIND_RECORD, 32'd2);
    transfer_item(KIND_RECORD, 32'd3);
    transfer_item(KIND_RECORD, 32'h7FFF_FFFF);
    transfer_item(KIND_RECORD, 32'h8000_0000);
    transfer_item(KIND_RECORD, 32'h4000_0000);
    transfer_item(KIND_RECORD, 32'h0000_FFFF);
    transfer_item(KIND_RECORD, 32'h0001_0000);
    transfer_item(KIND_REPORT, 32'hAAAA_AAAA);
    transfer_item(KIND_REPORT, '0);
    transfer_item(KIND_RECORD, 32'd100);
    transfer_item(KIND_REPORT, '1);
    wait_drained();

    send_bursts(PHASE_ITEMS);

    // output held off while the sender keeps pushing reports
    hold_req = 1'b1;
    for (int i = 0; i < 40; i++) begin
      if (i % 4 == 3) transfer_item(KIND_REPORT, $urandom);
      else transfer_item(KIND_RECORD, pick_latency(PROFILE_LOG));
    end
    wait_drained();

    send_idle_pct = 81;
    stall_pct     = 0;
    send_bursts(PHASE_ITEMS);
    send_idle_pct = 0;
    stall_pct     = 81;
    send_bursts(PHASE_ITEMS);
    send_idle_pct = 9;
    stall_pct     = 9;
    send_bursts(PHASE_ITEMS);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("covered %0d latency records and %0d reports over four idle patterns",
             sb.n_records, sb.n_reports);
    $display("%0d reports checked, %0d distinct p99 bounds seen, %0d mismatches",
             sb.n_checked, $countones(sb.p99_seen), sb.n_errors);
    if (sb.n_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
